// ===== hdl/audio_loop_overdub_feedback_top_defines.svh =====
// Assertion macros used by the looper's checker file.
`ifndef AUDIO_LOOP_OVERDUB_FEEDBACK_TOP_DEFINES_SVH
`define AUDIO_LOOP_OVERDUB_FEEDBACK_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define ALOFB_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define ALOFB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/alofb_pkg.sv =====
// Shared types, constants and helpers for the overdub/feedback looper.
`default_nettype none
package alofb_pkg;

   // Word on the request channel
   typedef struct packed {
      logic              action;
      logic signed [23:0] sample_in;
   } req_payload_type;

   // Word on the response channel
   typedef struct packed {
      logic signed [23:0] sample_out;
      logic [14:0]        block_position;
   } rsp_payload_type;

   // Controller -> datapath commands
   typedef struct packed {
      logic load;
      logic sweep_init;
      logic sweep_step;
      logic rd;
      logic mul;
      logic sum;
      logic ramp;
      logic finish;
      logic clear;
   } ctrl_cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      logic sweep_last;
   } ctrl_status_type;

   // Action codes
   localparam logic ACT_PROCESS = 1'b0;
   localparam logic ACT_CLEAR   = 1'b1;

   // Register indexes (paddr[3:2])
   localparam logic [1:0] REG_RECORD_GAIN   = 2'd0;
   localparam logic [1:0] REG_FEEDBACK_GAIN = 2'd1;
   localparam logic [1:0] REG_LOOP_LENGTH   = 2'd2;

   localparam int          PADDR_W         = 4;
   localparam int          LEN_W           = 17;      // clamped length, up to MAX_BLOCKS
   localparam logic [15:0] LOOP_LEN_RESET  = 16'd15000;
   localparam logic [15:0] RAMP_UNITY      = 16'd32768; // 1.0 in Q1.15

   function automatic logic signed [23:0] sat24(input logic signed [40:0] v);
      if (v > 41'sd8388607)
         return 24'sd8388607;
      if (v < -41'sd8388608)
         return -24'sd8388608;
      return $signed(v[23:0]);
   endfunction

endpackage
`default_nettype wire

// ===== hdl/alofb_csr.sv =====
// APB-style configuration registers: record gain, feedback gain, loop length.
`default_nettype none
module alofb_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [alofb_pkg::PADDR_W-1:0] paddr,
   input  wire logic [31:0]                   pwdata,
   output logic      [31:0]                   prdata,
   output logic                               pready,
   output logic      [14:0]                   record_gain,
   output logic      [14:0]                   feedback_gain,
   output logic      [15:0]                   loop_length
);
   import alofb_pkg::*;

   logic [14:0] record_gain_ff, record_gain_in;
   logic [14:0] feedback_gain_ff, feedback_gain_in;
   logic [15:0] loop_length_ff, loop_length_in;
   logic        wr_en;
   logic [1:0]  reg_sel;

   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[3:2];
   assign pready  = 1'b1;

   always_comb begin
      record_gain_in   = record_gain_ff;
      feedback_gain_in = feedback_gain_ff;
      loop_length_in   = loop_length_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_RECORD_GAIN:   record_gain_in   = pwdata[14:0];
            REG_FEEDBACK_GAIN: feedback_gain_in = pwdata[14:0];
            REG_LOOP_LENGTH:   loop_length_in   = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         record_gain_ff   <= '0;
         feedback_gain_ff <= '0;
         loop_length_ff   <= LOOP_LEN_RESET;
      end else begin
         record_gain_ff   <= record_gain_in;
         feedback_gain_ff <= feedback_gain_in;
         loop_length_ff   <= loop_length_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_RECORD_GAIN:   prdata = {17'd0, record_gain_ff};
         REG_FEEDBACK_GAIN: prdata = {17'd0, feedback_gain_ff};
         REG_LOOP_LENGTH:   prdata = {16'd0, loop_length_ff};
         default:           prdata = '0;
      endcase
   end

   assign record_gain   = record_gain_ff;
   assign feedback_gain = feedback_gain_ff;
   assign loop_length   = loop_length_ff;

endmodule
`default_nettype wire

// ===== hdl/alofb_ctrl.sv =====
// Sequencer: reset sweep, clear sweep and the per-sample step chain.
`default_nettype none
module alofb_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic                        req_action,
   output logic                             req_ready,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output alofb_pkg::ctrl_cmd_type          cmd,
   input  wire alofb_pkg::ctrl_status_type  status
);
   import alofb_pkg::*;

   typedef enum logic [2:0] {
      ST_INIT, ST_IDLE, ST_SWEEP, ST_RD, ST_MUL, ST_SUM, ST_RAMP, ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      clr_ff, clr_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   assign out_free = ~out_valid_ff | rsp_ready;

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      cmd      = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.sweep_step = 1'b1;
            if (status.sweep_last)
               state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               clr_in   = (req_action == ACT_CLEAR);
               if (req_action == ACT_CLEAR) begin
                  cmd.sweep_init = 1'b1;
                  state_in       = ST_SWEEP;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (status.sweep_last)
               state_in = ST_FIN;
         end
         ST_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_RAMP;
         end
         ST_RAMP: begin
            cmd.ramp = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // hold here until the output register can take the word
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
      cmd.clear = clr_ff;

      out_valid_in = out_valid_ff;
      if (cmd.finish)
         out_valid_in = 1'b1;
      else if (out_valid_ff && rsp_ready)
         out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         clr_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

endmodule
`default_nettype wire

// ===== hdl/alofb_dp.sv =====
// Datapath: loop memory, position counters, gain/ramp arithmetic, output word.
`default_nettype none
module alofb_dp #(
   parameter int SAMPLES_PER_BLOCK = 32,
   parameter int MAX_BLOCKS        = 32768
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire alofb_pkg::ctrl_cmd_type     cmd,
   output alofb_pkg::ctrl_status_type       status,
   input  wire alofb_pkg::req_payload_type  req_payload,
   output alofb_pkg::rsp_payload_type       rsp_payload,
   input  wire logic [14:0]                 record_gain,
   input  wire logic [14:0]                 feedback_gain,
   input  wire logic [15:0]                 loop_length
);
   import alofb_pkg::*;

   localparam int SW        = $clog2(SAMPLES_PER_BLOCK);
   localparam int BW        = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int MEM_WORDS = MAX_BLOCKS * SAMPLES_PER_BLOCK;
   localparam int AW        = $clog2(MEM_WORDS);
   localparam int Den       = SAMPLES_PER_BLOCK - 1;

   // loop memory, contents cleared by the sweep
   logic [23:0] mem [MEM_WORDS];

   logic [BW-1:0]      blk_ff;
   logic [SW-1:0]      s_ff;
   logic [AW-1:0]      addr_ff;
   logic [AW-1:0]      sw_addr_ff, sw_end_ff;
   logic signed [23:0] x_ff, rd_ff, v_ff;
   logic signed [39:0] pf_ff, pr_ff;
   logic signed [40:0] pw_ff;
   logic [15:0]        r_ff;
   rsp_payload_type    out_ff;

   logic [LEN_W-1:0]   len;
   logic [15:0]        ramp_tab [SAMPLES_PER_BLOCK];
   logic [AW-1:0]      addr_calc;
   logic               blk_first, blk_last;
   logic [15:0]        r_sel;
   logic [31:0]        clr_words;
   logic signed [40:0] acc_sum, acc_sh, pw_rnd, pw_sh;
   logic signed [23:0] wr_val;
   logic [LEN_W-1:0]   blk_inc;
   logic [BW-1:0]      blk_next;
   logic               s_wrap;
   logic [31:0]        blk_wide;
   logic               mem_we;
   logic [AW-1:0]      mem_wa;
   logic [23:0]        mem_wd;

   // Q1.15 rising ramp, one entry per sample slot
   for (genvar g = 0; g < SAMPLES_PER_BLOCK; g++) begin : g_ramp
      assign ramp_tab[g] = 16'((g * 32768 + Den / 2) / Den);
   end

   // effective length clamped to [1, MAX_BLOCKS]
   always_comb begin
      if (loop_length == 16'd0)
         len = LEN_W'(1);
      else if ({1'b0, loop_length} > LEN_W'(MAX_BLOCKS))
         len = LEN_W'(MAX_BLOCKS);
      else
         len = {1'b0, loop_length};
   end

   assign addr_calc = AW'(blk_ff) * AW'(SAMPLES_PER_BLOCK) + AW'(s_ff);
   assign blk_first = (blk_ff == '0);
   assign blk_last  = (LEN_W'(blk_ff) == len - LEN_W'(1));

   always_comb begin
      if (blk_first)
         r_sel = ramp_tab[s_ff];
      else if (blk_last)
         r_sel = RAMP_UNITY - ramp_tab[s_ff];
      else
         r_sel = RAMP_UNITY;   // v*1.0 rounds back to v
   end

   assign clr_words = 32'(len) * 32'(SAMPLES_PER_BLOCK) - 32'd1;

   assign acc_sum = 41'(pf_ff) + 41'(pr_ff) + 41'sd8192;
   assign acc_sh  = acc_sum >>> 14;
   assign pw_rnd  = pw_ff + 41'sd16384;
   assign pw_sh   = pw_rnd >>> 15;
   assign wr_val  = sat24(pw_sh);

   // position advance
   assign s_wrap   = (s_ff == SW'(SAMPLES_PER_BLOCK - 1));
   assign blk_inc  = LEN_W'(blk_ff) + LEN_W'(1);
   assign blk_next = (blk_inc >= len) ? '0 : blk_inc[BW-1:0];
   assign blk_wide = 32'(blk_ff);

   // single write port shared by sweep and write-back
   assign mem_we = cmd.sweep_step | (cmd.finish & ~cmd.clear);
   assign mem_wa = cmd.sweep_step ? sw_addr_ff : addr_ff;
   assign mem_wd = cmd.sweep_step ? 24'd0 : wr_val;

   always_ff @(posedge clock) begin
      if (mem_we)
         mem[mem_wa] <= mem_wd;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd)
         rd_ff <= $signed(mem[addr_ff]);
   end

   // control state: position and sweep pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         blk_ff     <= '0;
         s_ff       <= '0;
         sw_addr_ff <= '0;
         sw_end_ff  <= AW'(MEM_WORDS - 1);
      end else begin
         if (cmd.sweep_init) begin
            sw_addr_ff <= '0;
            sw_end_ff  <= clr_words[AW-1:0];
         end else if (cmd.sweep_step) begin
            sw_addr_ff <= sw_addr_ff + AW'(1);
         end
         if (cmd.finish && !cmd.clear) begin
            if (s_wrap) begin
               s_ff   <= '0;
               blk_ff <= blk_next;
            end else begin
               s_ff <= s_ff + SW'(1);
            end
         end
      end
   end

   // arithmetic pipeline registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff    <= req_payload.sample_in;
         addr_ff <= addr_calc;
         r_ff    <= r_sel;
      end
      if (cmd.mul) begin
         pf_ff <= 40'(rd_ff) * 40'($signed({1'b0, feedback_gain}));
         pr_ff <= 40'(x_ff) * 40'($signed({1'b0, record_gain}));
      end
      if (cmd.sum)
         v_ff <= sat24(acc_sh);
      if (cmd.ramp)
         pw_ff <= 41'(v_ff) * 41'($signed({1'b0, r_ff}));
      if (cmd.finish) begin
         out_ff.sample_out     <= cmd.clear ? 24'sd0 : wr_val;
         out_ff.block_position <= blk_wide[14:0];
      end
   end

   assign status.sweep_last = (sw_addr_ff == sw_end_ff);
   assign rsp_payload       = out_ff;

endmodule
`default_nettype wire

// ===== hdl/audio_loop_overdub_feedback_top.sv =====
// Loop recorder with overdub and feedback: top level.
// Process word: accepted in idle, then stepped through the read / multiply / sum / ramp
//   / write-back step chain on one memory port; the next word is taken only back in idle.
// Clear word: sweeps L*SAMPLES_PER_BLOCK words at one per cycle, then answers through FIN.
// Reset: control clears at once, then a sweep zeroes all MAX_BLOCKS*SAMPLES_PER_BLOCK
//   words (1048576 at defaults) with req_ready low; CSR writes work throughout.
`default_nettype none
module audio_loop_overdub_feedback_top #(
   parameter int SAMPLES_PER_BLOCK = 32,
   parameter int MAX_BLOCKS        = 32768
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire alofb_pkg::req_payload_type    req_payload,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output alofb_pkg::rsp_payload_type         rsp_payload,
   // configuration port
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [alofb_pkg::PADDR_W-1:0] paddr,
   input  wire logic [31:0]                   pwdata,
   output logic      [31:0]                   prdata,
   output logic                               pready
);
   import alofb_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   logic [14:0]     record_gain;
   logic [14:0]     feedback_gain;
   logic [15:0]     loop_length;

   // register file; the user must hold values steady while a word is in flight, it is not enforced
   alofb_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .record_gain   (record_gain),
      .feedback_gain (feedback_gain),
      .loop_length   (loop_length)
   );

   // sequencer: one word at a time, FIN waits for the output register to free up
   alofb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_payload.action),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .status     (status)
   );

   // memory, position counters, fixed-point math and the output word register
   alofb_dp #(
      .SAMPLES_PER_BLOCK (SAMPLES_PER_BLOCK),
      .MAX_BLOCKS        (MAX_BLOCKS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_payload   (req_payload),
      .rsp_payload   (rsp_payload),
      .record_gain   (record_gain),
      .feedback_gain (feedback_gain),
      .loop_length   (loop_length)
   );

endmodule
`default_nettype wire

// ===== hdl/alofb_chk.sv =====
// Port-level checker for the looper top, attached by bind.
`default_nettype none
`include "audio_loop_overdub_feedback_top_defines.svh"
module alofb_chk (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire alofb_pkg::rsp_payload_type rsp_payload
);
   import alofb_pkg::*;

   logic [1:0] pend_ff, pend_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid & req_ready;
   assign rsp_acc = rsp_valid & rsp_ready;

   // words accepted but not yet answered
   always_comb begin
      pend_in = pend_ff;
      if (req_acc && !rsp_acc)
         pend_in = pend_ff + 2'd1;
      else if (!req_acc && rsp_acc)
         pend_in = pend_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         pend_ff <= '0;
      else
         pend_ff <= pend_in;
   end

   `ALOFB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "response word changed while stalled")
   `ALOFB_ASSERT_IMPLY(a_rsp_owed, rsp_valid, pend_ff != 2'd0, "response word with no request outstanding")
   `ALOFB_ASSERT_IMPLY(a_one_in_work, req_ready, pend_ff <= 2'd1, "ready while a word is still being worked")
   `ALOFB_ASSERT_IMPLY(a_init_sweep, $fell(reset), !req_ready, "ready before the reset sweep finished")

endmodule

bind audio_loop_overdub_feedback_top alofb_chk u_alofb_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
`default_nettype wire
